>>> hdl/assert_macros.svh
// Assertion macros for the coin change way counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CCW_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCW_ASSERT(lbl, prop, msg)
`define CCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hdl/ccw_pkg.sv
// Shared types and constants for the coin change way counter.
package ccw_pkg;
	localparam int TARGET_W = 10;
	localparam int COIN_W   = 10;
	localparam int OUT_W    = 32;
	localparam int APB_AW   = 2;
	localparam int APB_DW   = 32;

	localparam logic [APB_AW-1:0] REG_TARGET_ADDR = 2'd0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_REPORT
	} ccw_state_t;
endpackage

>>> hdl/ccw_table_mem.sv
// Count table memory: one write port, two registered read ports.
module ccw_table_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

>>> hdl/ccw_ctrl.sv
// Sequencer and read-modify-write datapath that sweeps the count table.
`include "assert_macros.svh"
module ccw_ctrl #(
	parameter int MAX_AMOUNT  = 1023,
	parameter int COUNT_WIDTH = 32,
	parameter int AW          = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ccw_pkg::TARGET_W-1:0]  target,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [ccw_pkg::COIN_W-1:0]    coin_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ccw_pkg::OUT_W-1:0]     way_count,
	output logic                          saturated,
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [COUNT_WIDTH-1:0]        mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr_a,
	output logic [AW-1:0]                 mem_raddr_b,
	input  logic [COUNT_WIDTH-1:0]        mem_rdata_a,
	input  logic [COUNT_WIDTH-1:0]        mem_rdata_b
);
	import ccw_pkg::*;

	localparam int CW = (AW > TARGET_W) ? AW : TARGET_W;
	localparam logic [COUNT_WIDTH-1:0] LIM = '1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_AMOUNT);

	ccw_state_t state_q, state_nxt;

	logic [AW-1:0] t_act;
	logic          coin_ok;
	logic          acc;
	logic          out_free;
	logic          out_load;
	logic          issue;

	logic [AW-1:0] j_q, clr_q, coin_q, t_q;
	logic          vld_s1;
	logic [AW-1:0] waddr_s1, lo_addr_s1;

	logic                   lastw_vld_q;
	logic [AW-1:0]          lastw_addr_q;
	logic [COUNT_WIDTH-1:0] lastw_data_q;
	logic                   fwd;
	logic [COUNT_WIDTH-1:0] lo_val;
	logic [COUNT_WIDTH:0]   sum;
	logic                   sat;
	logic [COUNT_WIDTH-1:0] upd;

	logic                   ovf_q;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       way_count_q;
	logic                   saturated_q;

	// clamp the target to the table
	always_comb begin
		if (CW'(target) > CW'(MAX_AMOUNT)) begin
			t_act = LAST_ADDR;
		end else begin
			t_act = AW'(target);
		end
	end

	assign coin_ok  = (coin_value != '0) && (CW'(coin_value) <= CW'(t_act));
	assign acc      = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// write stage: saturating add, forward the write of the previous cycle
	assign fwd    = lastw_vld_q && (lastw_addr_q == lo_addr_s1);
	assign lo_val = fwd ? lastw_data_q : mem_rdata_b;
	assign sum    = {1'b0, mem_rdata_a} + {1'b0, lo_val};
	assign sat    = sum >= {1'b0, LIM};
	assign upd    = sat ? LIM : sum[COUNT_WIDTH-1:0];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					if (mode) state_nxt = ST_REPORT;
					else if (coin_ok) state_nxt = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (j_q == t_q) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: state_nxt = ST_IDLE;
			ST_REPORT: begin
				if (out_free) state_nxt = ST_CLEAR;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		mem_re      = 1'b0;
		mem_raddr_a = j_q;
		mem_raddr_b = j_q - coin_q;
		mem_we      = 1'b0;
		mem_waddr   = waddr_s1;
		mem_wdata   = upd;
		issue       = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = COUNT_WIDTH'(clr_q == '0);
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				mem_re      = in_valid && mode;
				mem_raddr_a = t_act;
			end
			ST_SWEEP: begin
				mem_re = 1'b1;
				issue  = 1'b1;
			end
			ST_DRAIN: ;
			ST_REPORT: out_load = out_free;
			default: ;
		endcase
		if (vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = waddr_s1;
			mem_wdata = upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			lastw_vld_q <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			vld_s1      <= issue;
			lastw_vld_q <= mem_we;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			else if (out_load) clr_q <= '0;
			if (out_load) ovf_q <= 1'b0;
			else if (vld_s1 && sat) ovf_q <= 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !mode) begin
			j_q    <= AW'(coin_value);
			coin_q <= AW'(coin_value);
			t_q    <= t_act;
		end else if (issue) begin
			j_q <= j_q + 1'b1;
		end
		waddr_s1     <= j_q;
		lo_addr_s1   <= mem_raddr_b;
		lastw_addr_q <= mem_waddr;
		lastw_data_q <= mem_wdata;
		if (out_load) begin
			way_count_q <= OUT_W'(mem_rdata_a);
			saturated_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign way_count = way_count_q;
	assign saturated = saturated_q;

	`CCW_ASSERT_ALWAYS(a_clear_stalls, (state_q == ST_CLEAR) |-> in_stall, "input taken during clear")
	`CCW_ASSERT(a_write_in_range, vld_s1 |-> (waddr_s1 >= coin_q && waddr_s1 <= t_q), "sweep write out of range")
	`CCW_ASSERT(a_fwd_unit_coin, (vld_s1 && fwd) |-> (coin_q == AW'(1)), "forwarding for coin above one")
	`CCW_ASSERT(a_report_restarts, out_load |=> (state_q == ST_CLEAR && !ovf_q && clr_q == '0), "report did not restart table")
endmodule

>>> hdl/coin_change_way_counter.sv
// Coin change way counter: each coin request sweeps the count table from coin to target,
// one entry per cycle; a coin of 0 or above target is accepted without a sweep.
// A report request reads the target entry and loads the result once the output register is free,
// and then a clear rebuilds the table. Results leave through an output register, so the clear
// runs while a result waits. After reset the table is cleared before the first request is taken.
module coin_change_way_counter #(
	parameter int MAX_AMOUNT  = 1023,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ccw_pkg::APB_AW-1:0]    paddr,
	input  logic [ccw_pkg::APB_DW-1:0]    pwdata,
	output logic [ccw_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [ccw_pkg::COIN_W-1:0]    coin_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ccw_pkg::OUT_W-1:0]     way_count,
	output logic                          saturated
);
	import ccw_pkg::*;

	localparam int DEPTH = MAX_AMOUNT + 1;
	localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;

	logic [TARGET_W-1:0]    target_q;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr_a, mem_raddr_b;
	logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_TARGET_ADDR) begin
			target_q <= pwdata[TARGET_W-1:0];
		end
	end

	assign prdata = (paddr == REG_TARGET_ADDR) ? APB_DW'(target_q) : '0;

	ccw_table_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (AW),
		.DATA_W (COUNT_WIDTH)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (mem_re),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	ccw_ctrl #(
		.MAX_AMOUNT  (MAX_AMOUNT),
		.COUNT_WIDTH (COUNT_WIDTH),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.target      (target_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.coin_value  (coin_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.way_count   (way_count),
		.saturated   (saturated),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.mem_rdata_a (mem_rdata_a),
		.mem_rdata_b (mem_rdata_b)
	);
endmodule
